// File: hdl/chebyshev_waveshaper_feedback_unit_assert.svh
// Assertion macros shared by the checker of the waveshaper block.
// Each macro expects signals named clock and reset in the using scope.
`ifndef CHEBYSHEV_WAVESHAPER_FEEDBACK_UNIT_ASSERT_SVH
`define CHEBYSHEV_WAVESHAPER_FEEDBACK_UNIT_ASSERT_SVH

// Same-cycle implication.
`define CWF_CHECK_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define CWF_CHECK_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hdl/cwfb_pkg.sv
// Shared types and constants of the Chebyshev waveshaper with feedback.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
package cwfb_pkg;

   localparam int MAX_HALF_ORDER_DEF = 15;
   localparam int SAMPLE_WIDTH_DEF   = 16;

   localparam int GAIN_W      = 17;
   localparam int GAIN_FRAC   = 16;
   localparam int HALF_ORDER_W = 4;
   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 32;

   localparam logic [CSR_INDEX_W-1:0] CSR_PRE_GAIN      = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_POST_GAIN     = 8'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_FEEDBACK_GAIN = 8'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_HALF_ORDER    = 8'd3;

   localparam logic [GAIN_W-1:0] GAIN_UNITY = 17'h10000;

   typedef struct packed {
      logic [GAIN_W-1:0] pre_gain;
      logic [GAIN_W-1:0] post_gain;
      logic [GAIN_W-1:0] feedback_gain;
   } cwfb_gain_type;

   typedef enum logic [2:0] {
      LANE_IDLE,
      LANE_GAIN,
      LANE_MIX,
      LANE_STEP,
      LANE_POST,
      LANE_DONE
   } cwfb_lane_state_type;

endpackage

// File: hdl/cwfb_lane.sv
// One channel of the waveshaper: gain/feedback mix, Chebyshev recurrence, post gain.
// Depends on cwfb_pkg; starts only when idle, holds its result until released.
`timescale 1ns / 1ps
module cwfb_lane
   import cwfb_pkg::*;
#(
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
   parameter int STEP_W       = 5
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic signed [SAMPLE_WIDTH-1:0] sample,
   input  cwfb_gain_type                  gains,
   input  logic [STEP_W-1:0]              steps,
   input  logic                           release_result,
   output logic                           idle,
   output logic                           done,
   output logic signed [SAMPLE_WIDTH-1:0] result
);

   localparam int W  = SAMPLE_WIDTH;
   localparam int SW = W + 4;
   localparam int PW = W + GAIN_W + 1;
   localparam logic signed [W-1:0] S_MAX = {1'b0, {(W-1){1'b1}}};
   localparam logic signed [W-1:0] S_MIN = {1'b1, {(W-1){1'b0}}};

   cwfb_lane_state_type state_ff, state_in;
   logic signed [W-1:0]    sample_ff, sample_in;
   logic signed [PW-1:0]   acc_ff, acc_in;
   logic signed [W-1:0]    x_ff, x_in;
   logic signed [W-1:0]    cur_ff, cur_in;
   logic signed [W-1:0]    prev_ff, prev_in;
   logic [STEP_W-1:0]      cnt_ff, cnt_in;
   logic signed [W-1:0]    fb_ff, fb_in;
   logic signed [W-1:0]    res_ff, res_in;

   logic signed [GAIN_W:0] pre_sx, post_sx, fbg_sx;
   logic signed [PW-1:0]   pre_prod, fb_prod, post_prod;
   logic signed [PW:0]     mix_sum;
   logic signed [2*W-1:0]  step_prod;
   logic signed [SW-1:0]   step_diff;
   logic signed [W-1:0]    mix_sat, step_sat, post_sat;
   logic [STEP_W-1:0]      cnt_next;

   function automatic logic signed [W-1:0] sat_w(input logic signed [SW-1:0] v);
      logic fits;
      fits = (v[SW-1:W-1] == {(SW-W+1){1'b0}}) || (v[SW-1:W-1] == {(SW-W+1){1'b1}});
      if (fits) begin
         return v[W-1:0];
      end else if (v[SW-1]) begin
         return S_MIN;
      end else begin
         return S_MAX;
      end
   endfunction

   assign pre_sx  = $signed({1'b0, gains.pre_gain});
   assign post_sx = $signed({1'b0, gains.post_gain});
   assign fbg_sx  = $signed({1'b0, gains.feedback_gain});

   assign pre_prod  = PW'(sample_ff) * PW'(pre_sx);
   assign fb_prod   = PW'(fb_ff) * PW'(fbg_sx);
   assign mix_sum   = (PW+1)'(acc_ff) + (PW+1)'(fb_prod);
   assign mix_sat   = sat_w(SW'($signed(mix_sum[PW:GAIN_FRAC])));

   // factor 2 of the recurrence is folded into the shift
   assign step_prod = (2*W)'(x_ff) * (2*W)'(cur_ff);
   assign step_diff = SW'($signed(step_prod[2*W-1:W-2])) - SW'(prev_ff);
   assign step_sat  = sat_w(step_diff);

   assign post_prod = PW'(cur_ff) * PW'(post_sx);
   assign post_sat  = sat_w(SW'($signed(post_prod[PW-1:GAIN_FRAC])));

   assign cnt_next  = cnt_ff + STEP_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= LANE_IDLE;
         fb_ff    <= '0;
      end else begin
         state_ff <= state_in;
         fb_ff    <= fb_in;
      end
      sample_ff <= sample_in;
      acc_ff    <= acc_in;
      x_ff      <= x_in;
      cur_ff    <= cur_in;
      prev_ff   <= prev_in;
      cnt_ff    <= cnt_in;
      res_ff    <= res_in;
   end

   always_comb begin
      state_in  = state_ff;
      sample_in = sample_ff;
      acc_in    = acc_ff;
      x_in      = x_ff;
      cur_in    = cur_ff;
      prev_in   = prev_ff;
      cnt_in    = cnt_ff;
      fb_in     = fb_ff;
      res_in    = res_ff;
      case (state_ff)
         LANE_IDLE: begin
            if (start) begin
               sample_in = sample;
               state_in  = LANE_GAIN;
            end
         end
         LANE_GAIN: begin
            acc_in   = pre_prod;
            state_in = LANE_MIX;
         end
         LANE_MIX: begin
            x_in     = mix_sat;
            cur_in   = mix_sat;
            prev_in  = S_MAX;
            cnt_in   = '0;
            state_in = (steps == '0) ? LANE_POST : LANE_STEP;
         end
         LANE_STEP: begin
            prev_in = cur_ff;
            cur_in  = step_sat;
            cnt_in  = cnt_next;
            if (cnt_next == steps) begin
               state_in = LANE_POST;
            end
         end
         LANE_POST: begin
            fb_in    = cur_ff;
            res_in   = post_sat;
            state_in = LANE_DONE;
         end
         LANE_DONE: begin
            if (release_result) begin
               state_in = LANE_IDLE;
            end
         end
         default: begin
            state_in = LANE_IDLE;
         end
      endcase
   end

   assign idle   = (state_ff == LANE_IDLE);
   assign done   = (state_ff == LANE_DONE);
   assign result = res_ff;

endmodule

// File: hdl/cwfb_merge.sv
// Merge stage: joins the two lane results into one output beat and holds it.
// Depends on cwfb_pkg for shared constants only.
`timescale 1ns / 1ps
module cwfb_merge
   import cwfb_pkg::*;
#(
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           left_done,
   input  logic                           right_done,
   input  logic signed [SAMPLE_WIDTH-1:0] left_result,
   input  logic signed [SAMPLE_WIDTH-1:0] right_result,
   output logic                           take,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic signed [SAMPLE_WIDTH-1:0] rsp_left_out,
   output logic signed [SAMPLE_WIDTH-1:0] rsp_right_out
);

   logic                           valid_ff, valid_in;
   logic signed [SAMPLE_WIDTH-1:0] left_ff, left_in;
   logic signed [SAMPLE_WIDTH-1:0] right_ff, right_in;
   logic                           slot_free;

   // slot frees when empty or when the held beat leaves this cycle
   assign slot_free = !valid_ff || !rsp_stall;
   assign take      = left_done && right_done && slot_free;

   always_comb begin
      valid_in = valid_ff;
      left_in  = left_ff;
      right_in = right_ff;
      if (take) begin
         valid_in = 1'b1;
         left_in  = left_result;
         right_in = right_result;
      end else if (slot_free) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      left_ff  <= left_in;
      right_ff <= right_in;
   end

   assign rsp_valid     = valid_ff;
   assign rsp_left_out  = left_ff;
   assign rsp_right_out = right_ff;

endmodule

// File: hdl/chebyshev_waveshaper_feedback_unit.sv
// Top level of the stereo Chebyshev waveshaper with feedback.
// Depends on cwfb_pkg, cwfb_lane and cwfb_merge.
//
//   channel  direction  handshake            payload
//   req_     in         req_valid/req_stall  req_left_sample, req_right_sample
//   rsp_     out        rsp_valid/rsp_stall  rsp_left_out, rsp_right_out
//   csr_     in         csr_valid/csr_ready  csr_index, csr_data
//
// An item runs gain, mix, 2*min(half_order, MAX_HALF_ORDER) recurrence steps in each
// lane's multiplier and post gain from accept to result; a new item is taken in the cycle
// after the lanes hand their results to the output register.
// Reset clears registers to their reset values and the feedback state to zero.
// A stalled result holds in the output register while the lanes work on the next beat.
`timescale 1ns / 1ps
module chebyshev_waveshaper_feedback_unit
   import cwfb_pkg::*;
#(
   parameter int MAX_HALF_ORDER = MAX_HALF_ORDER_DEF,
   parameter int SAMPLE_WIDTH   = SAMPLE_WIDTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic signed [SAMPLE_WIDTH-1:0] req_left_sample,
   input  logic signed [SAMPLE_WIDTH-1:0] req_right_sample,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic signed [SAMPLE_WIDTH-1:0] rsp_left_out,
   output logic signed [SAMPLE_WIDTH-1:0] rsp_right_out,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [CSR_INDEX_W-1:0]         csr_index,
   input  logic [CSR_DATA_W-1:0]          csr_data
);

   localparam int STEP_W = $clog2(2 * MAX_HALF_ORDER + 1);

   cwfb_gain_type             gains_ff, gains_in;
   logic [HALF_ORDER_W-1:0]   half_order_ff, half_order_in;
   logic [STEP_W-1:0]         steps;
   logic                      start;
   logic                      take;
   logic                      left_idle, right_idle;
   logic                      left_done, right_done;
   logic signed [SAMPLE_WIDTH-1:0] left_result, right_result;

   assign csr_ready = 1'b1;

   always_comb begin
      gains_in      = gains_ff;
      half_order_in = half_order_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_PRE_GAIN:      gains_in.pre_gain      = csr_data[GAIN_W-1:0];
            CSR_POST_GAIN:     gains_in.post_gain     = csr_data[GAIN_W-1:0];
            CSR_FEEDBACK_GAIN: gains_in.feedback_gain = csr_data[GAIN_W-1:0];
            CSR_HALF_ORDER:    half_order_in          = csr_data[HALF_ORDER_W-1:0];
            default: begin
               // drop writes to unknown registers
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gains_ff.pre_gain      <= GAIN_UNITY;
         gains_ff.post_gain     <= GAIN_UNITY;
         gains_ff.feedback_gain <= '0;
         half_order_ff          <= '0;
      end else begin
         gains_ff      <= gains_in;
         half_order_ff <= half_order_in;
      end
   end

   // clamp the order, then two recurrence steps per unit of half order
   assign steps = (32'(half_order_ff) > 32'(MAX_HALF_ORDER)) ?
                  STEP_W'(2 * MAX_HALF_ORDER) : STEP_W'({half_order_ff, 1'b0});

   assign req_stall = !(left_idle && right_idle);
   assign start     = req_valid && !req_stall;

   cwfb_lane #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .STEP_W       (STEP_W)
   ) u_lane_left (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .sample         (req_left_sample),
      .gains          (gains_ff),
      .steps          (steps),
      .release_result (take),
      .idle           (left_idle),
      .done           (left_done),
      .result         (left_result)
   );

   cwfb_lane #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .STEP_W       (STEP_W)
   ) u_lane_right (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .sample         (req_right_sample),
      .gains          (gains_ff),
      .steps          (steps),
      .release_result (take),
      .idle           (right_idle),
      .done           (right_done),
      .result         (right_result)
   );

   cwfb_merge #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_merge (
      .clock         (clock),
      .reset         (reset),
      .left_done     (left_done),
      .right_done    (right_done),
      .left_result   (left_result),
      .right_result  (right_result),
      .take          (take),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_left_out  (rsp_left_out),
      .rsp_right_out (rsp_right_out)
   );

endmodule

// File: hdl/cwfb_checker.sv
// Port-level checks of the waveshaper top level, attached by bind.
// Depends on cwfb_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "chebyshev_waveshaper_feedback_unit_assert.svh"
module cwfb_checker
   import cwfb_pkg::*;
#(
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_stall,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input logic signed [SAMPLE_WIDTH-1:0] rsp_left_out,
   input logic signed [SAMPLE_WIDTH-1:0] rsp_right_out
);

   // a held result beat keeps its payload
   `CWF_CHECK_NEXT(a_rsp_hold, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_left_out) && $stable(rsp_right_out),
      "result beat changed while stalled")

   // an accepted beat occupies the lanes
   `CWF_CHECK_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall,
      "input taken again right after a beat was accepted")

   // the path through the lanes passes gain, mix and post, so no result rises straight after accept
   `CWF_CHECK_NEXT(a_min_latency, req_valid && !req_stall,
      !$rose(rsp_valid) ##1 !$rose(rsp_valid),
      "result appeared too soon after accept")

   `CWF_CHECK_NOW(a_reset_empty, $past(reset), !rsp_valid,
      "result valid right after reset")

endmodule

bind chebyshev_waveshaper_feedback_unit cwfb_checker #(
   .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_cwfb_checker (.*);
